### rtl/bis_pkg.sv
// shared types and constants of the bilinear image scaler
package bis_pkg;

   localparam int COORD_W     = 12;
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = 3 * CHAN_W;
   localparam int SIZE_W      = 9;
   localparam int STEP_W      = 24;
   localparam int STEP_FRAC   = 16;
   localparam int CSR_W       = 24;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RESET  = 9'd160;
   localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RESET = 9'd120;
   localparam logic [STEP_W-1:0] STEP_RESET          = 24'h010000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_X_STEP        = 2'd2,
      CSR_Y_STEP        = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_WRITE   = 1'b0,
      CMD_REQUEST = 1'b1
   } command_type;

   // neighbour taps: bit 0 picks the right column, bit 1 the bottom row
   typedef enum logic [1:0] {
      TAP_TL = 2'd0,
      TAP_TR = 2'd1,
      TAP_BL = 2'd2,
      TAP_BR = 2'd3
   } tap_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_READ0,
      ST_READ1,
      ST_READ2,
      ST_READ3,
      ST_LAST,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic mul_en;
      logic map_en;
   } axis_ctl_type;

   typedef struct packed {
      logic    load_weights;
      logic    acc_en;
      logic    acc_first;
      tap_type tap;
   } blend_ctl_type;

endpackage

### rtl/bilinear_image_scaler.sv
// top level of the bilinear image scaler: control sequencer, registers, memory
// A write word stores one RGB source pixel at row * MAX_SOURCE_WIDTH + col in a
// single-port image memory; writes outside the store are
// dropped and never give a response. A request word maps its destination
// column and row through the Q8.16 steps, then reads the four neighbours one
// per cycle through the single memory port and blends them with one
// multiply-accumulate per channel. A request holds the input from acceptance
// to the next ready, and longer while the response register stays full. The
// image memory is not cleared at reset; every pixel must be written before a
// request reads it. The size and step registers may only be written while the
// block is idle.
module bilinear_image_scaler #(
   parameter int MAX_SOURCE_WIDTH = 256,
   parameter int MAX_SOURCE_HEIGHT = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [bis_pkg::COORD_W-1:0]      req_col,
   input  logic [bis_pkg::COORD_W-1:0]      req_row,
   input  logic [bis_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [bis_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [bis_pkg::CHAN_W-1:0]       req_blue_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bis_pkg::CHAN_W-1:0]       rsp_red_out,
   output logic [bis_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [bis_pkg::CHAN_W-1:0]       rsp_blue_out,
   input  logic                             csr_we,
   input  logic [bis_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bis_pkg::CSR_W-1:0]        csr_wdata
);
   import bis_pkg::*;

   localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
   localparam int MAW   = $clog2(DEPTH);
   localparam int XW    = $clog2(MAX_SOURCE_WIDTH);
   localparam int YW    = $clog2(MAX_SOURCE_HEIGHT);
   localparam int FAW   = 2 * COORD_W + 1;
   localparam int CMP_W = COORD_W + 1;

   // configuration registers
   logic [SIZE_W-1:0] source_width_ff, source_height_ff;
   logic [STEP_W-1:0] x_step_ff, y_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= SOURCE_WIDTH_RESET;
         source_height_ff <= SOURCE_HEIGHT_RESET;
         x_step_ff        <= STEP_RESET;
         y_step_ff        <= STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_X_STEP:        x_step_ff        <= csr_wdata[STEP_W-1:0];
            CSR_Y_STEP:        y_step_ff        <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff;

   logic          req_accept, is_request, out_free, rsp_load;
   axis_ctl_type  axis_ctl;
   blend_ctl_type blend_ctl;
   tap_type       rd_tap;

   logic [XW-1:0]        x0, x1, rd_x;
   logic [YW-1:0]        y0, y1, rd_y;
   logic [FRAC_BITS-1:0] frac_a, frac_b;

   logic           wr_in_range, mem_we;
   logic [FAW-1:0] wr_full, rd_full;
   logic [MAW-1:0] mem_addr;
   logic [PIXEL_W-1:0] mem_rdata, blend_rgb;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign is_request = (command_type'(req_command) == CMD_REQUEST);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept && is_request) state_in = ST_COORD;
         ST_COORD:  state_in = ST_READ0;
         ST_READ0:  state_in = ST_READ1;
         ST_READ1:  state_in = ST_READ2;
         ST_READ2:  state_in = ST_READ3;
         ST_READ3:  state_in = ST_LAST;
         ST_LAST:   state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: memory data follows the address in the next cycle
   always_comb begin
      axis_ctl.mul_en        = req_accept && is_request;
      axis_ctl.map_en        = 1'b0;
      blend_ctl.load_weights = 1'b0;
      blend_ctl.acc_en       = 1'b0;
      blend_ctl.acc_first    = 1'b0;
      blend_ctl.tap          = TAP_TL;
      rd_tap                 = TAP_TL;
      rsp_load               = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_COORD: axis_ctl.map_en = 1'b1;
         ST_READ0: begin
            blend_ctl.load_weights = 1'b1;
            rd_tap = TAP_TL;
         end
         ST_READ1: begin
            blend_ctl.acc_en    = 1'b1;
            blend_ctl.acc_first = 1'b1;
            blend_ctl.tap       = TAP_TL;
            rd_tap = TAP_TR;
         end
         ST_READ2: begin
            blend_ctl.acc_en = 1'b1;
            blend_ctl.tap    = TAP_TR;
            rd_tap = TAP_BL;
         end
         ST_READ3: begin
            blend_ctl.acc_en = 1'b1;
            blend_ctl.tap    = TAP_BL;
            rd_tap = TAP_BR;
         end
         ST_LAST: begin
            blend_ctl.acc_en = 1'b1;
            blend_ctl.tap    = TAP_BR;
         end
         ST_FINISH: rsp_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff <= blend_rgb;
      end
   end

   // memory addressing: writes only in idle, neighbour reads afterwards
   always_comb begin
      wr_in_range = (CMP_W'(req_col) < CMP_W'(MAX_SOURCE_WIDTH)) &&
                    (CMP_W'(req_row) < CMP_W'(MAX_SOURCE_HEIGHT));
      wr_full = FAW'(req_row) * FAW'(MAX_SOURCE_WIDTH) + FAW'(req_col);
      rd_x = rd_tap[0] ? x1 : x0;
      rd_y = rd_tap[1] ? y1 : y0;
      rd_full = FAW'(rd_y) * FAW'(MAX_SOURCE_WIDTH) + FAW'(rd_x);
      mem_we = req_accept && !is_request && wr_in_range;
      mem_addr = (state_ff == ST_IDLE) ? wr_full[MAW-1:0] : rd_full[MAW-1:0];
   end

   bis_image_mem #(
      .DEPTH(DEPTH)
   ) u_image_mem (
      .clock(clock),
      .we   (mem_we),
      .addr (mem_addr),
      .wdata({req_red_in, req_green_in, req_blue_in}),
      .rdata(mem_rdata)
   );

   bis_axis #(
      .MAX_SIZE (MAX_SOURCE_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_axis_x (
      .clock   (clock),
      .ctl     (axis_ctl),
      .dest    (req_col),
      .step    (x_step_ff),
      .size_cfg(source_width_ff),
      .lo      (x0),
      .hi      (x1),
      .frac    (frac_a)
   );

   bis_axis #(
      .MAX_SIZE (MAX_SOURCE_HEIGHT),
      .FRAC_BITS(FRAC_BITS)
   ) u_axis_y (
      .clock   (clock),
      .ctl     (axis_ctl),
      .dest    (req_row),
      .step    (y_step_ff),
      .size_cfg(source_height_ff),
      .lo      (y0),
      .hi      (y1),
      .frac    (frac_b)
   );

   bis_blend #(
      .FRAC_BITS(FRAC_BITS)
   ) u_blend (
      .clock (clock),
      .ctl   (blend_ctl),
      .frac_a(frac_a),
      .frac_b(frac_b),
      .pixel (mem_rdata),
      .rgb   (blend_rgb)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pixel_ff[PIXEL_W-1 -: CHAN_W];
   assign rsp_green_out = rsp_pixel_ff[PIXEL_W-1-CHAN_W -: CHAN_W];
   assign rsp_blue_out  = rsp_pixel_ff[CHAN_W-1:0];

endmodule

### rtl/bis_image_mem.sv
// single-port source image memory with registered read data
module bis_image_mem #(
   parameter int DEPTH = 65536,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [AW-1:0]            addr,
   input  logic [bis_pkg::PIXEL_W-1:0] wdata,
   output logic [bis_pkg::PIXEL_W-1:0] rdata
);
   import bis_pkg::*;

   logic [PIXEL_W-1:0] image_ff [DEPTH];
   logic [PIXEL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         image_ff[addr] <= wdata;
      end
      rdata_ff <= image_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/bis_axis.sv
// maps one destination coordinate to source neighbours and a fraction weight
module bis_axis #(
   parameter int MAX_SIZE = 256,
   parameter int FRAC_BITS = 16,
   localparam int IW = $clog2(MAX_SIZE)
) (
   input  logic                         clock,
   input  bis_pkg::axis_ctl_type        ctl,
   input  logic [bis_pkg::COORD_W-1:0]  dest,
   input  logic [bis_pkg::STEP_W-1:0]   step,
   input  logic [bis_pkg::SIZE_W-1:0]   size_cfg,
   output logic [IW-1:0]                lo,
   output logic [IW-1:0]                hi,
   output logic [FRAC_BITS-1:0]         frac
);
   import bis_pkg::*;

   localparam int POS_W = COORD_W + STEP_W;
   localparam int IP_W  = POS_W - STEP_FRAC;
   localparam int CW    = ($clog2(MAX_SIZE + 1) > SIZE_W) ? $clog2(MAX_SIZE + 1) : SIZE_W;

   logic [POS_W-1:0]     pos_ff;
   logic [IW-1:0]        lo_ff, lo_in;
   logic [IW-1:0]        hi_ff, hi_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;

   logic [CW-1:0]        size_ext, eff, last_wide;
   logic [IW-1:0]        last;
   logic [IP_W-1:0]      ip;
   logic [STEP_W-1:0]    frac_wide;

   always_comb begin
      size_ext = CW'(size_cfg);
      if (size_ext == '0) begin
         eff = CW'(1);
      end else if (size_ext > CW'(MAX_SIZE)) begin
         eff = CW'(MAX_SIZE);
      end else begin
         eff = size_ext;
      end
      last_wide = eff - CW'(1);
      last      = last_wide[IW-1:0];

      ip = pos_ff[POS_W-1:STEP_FRAC];
      // step fraction rescaled to FRAC_BITS, truncating or zero-filling
      frac_wide = {pos_ff[STEP_FRAC-1:0], {(STEP_W - STEP_FRAC){1'b0}}}
                  >> (STEP_W - FRAC_BITS);

      if (ip > IP_W'(last)) begin
         lo_in   = last;
         frac_in = '0;
      end else begin
         lo_in   = ip[IW-1:0];
         frac_in = frac_wide[FRAC_BITS-1:0];
      end
      hi_in = (lo_in == last) ? last : lo_in + IW'(1);
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         pos_ff <= POS_W'(dest) * POS_W'(step);
      end
      if (ctl.map_en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         frac_ff <= frac_in;
      end
   end

   assign lo   = lo_ff;
   assign hi   = hi_ff;
   assign frac = frac_ff;

endmodule

### rtl/bis_blend.sv
// bilinear weights and per-channel multiply-accumulate with rounding
module bis_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  bis_pkg::blend_ctl_type       ctl,
   input  logic [FRAC_BITS-1:0]         frac_a,
   input  logic [FRAC_BITS-1:0]         frac_b,
   input  logic [bis_pkg::PIXEL_W-1:0]  pixel,
   output logic [bis_pkg::PIXEL_W-1:0]  rgb
);
   import bis_pkg::*;

   localparam int WW = 2 * FRAC_BITS + 1;
   localparam int PW = 2 * FRAC_BITS + 2;
   localparam int AW = WW + CHAN_W;
   localparam logic [AW-1:0] HALF = AW'(1) << (2 * FRAC_BITS - 1);
   localparam logic [AW-1:0] CHAN_MAX = AW'((1 << CHAN_W) - 1);

   logic [WW-1:0] weight_ff [4];
   logic [WW-1:0] weight_in [4];
   logic [AW-1:0] acc_ff [3];
   logic [AW-1:0] acc_in [3];

   logic [FRAC_BITS:0] one, om_a, om_b;
   logic [PW-1:0]      prod_tl, prod_tr, prod_bl, prod_br;
   logic [WW-1:0]      weight_sel;
   logic [AW-1:0]      prod [3];
   logic [AW-1:0]      rounded [3];
   logic [AW-1:0]      scaled [3];

   always_comb begin
      one  = {1'b1, {FRAC_BITS{1'b0}}};
      om_a = one - {1'b0, frac_a};
      om_b = one - {1'b0, frac_b};
      prod_tl = PW'(om_a) * PW'(om_b);
      prod_tr = PW'({1'b0, frac_a}) * PW'(om_b);
      prod_bl = PW'(om_a) * PW'({1'b0, frac_b});
      prod_br = PW'({1'b0, frac_a}) * PW'({1'b0, frac_b});
      weight_in[TAP_TL] = prod_tl[WW-1:0];
      weight_in[TAP_TR] = prod_tr[WW-1:0];
      weight_in[TAP_BL] = prod_bl[WW-1:0];
      weight_in[TAP_BR] = prod_br[WW-1:0];
   end

   always_comb begin
      weight_sel = weight_ff[ctl.tap];
      for (int c = 0; c < 3; c++) begin
         prod[c] = AW'(weight_sel) * AW'(pixel[PIXEL_W-1-CHAN_W*c -: CHAN_W]);
         acc_in[c] = ctl.acc_first ? prod[c] : acc_ff[c] + prod[c];
         rounded[c] = acc_ff[c] + HALF;
         scaled[c] = rounded[c] >> (2 * FRAC_BITS);
         if (scaled[c] > CHAN_MAX) begin
            rgb[PIXEL_W-1-CHAN_W*c -: CHAN_W] = CHAN_MAX[CHAN_W-1:0];
         end else begin
            rgb[PIXEL_W-1-CHAN_W*c -: CHAN_W] = scaled[c][CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_weights) begin
         for (int t = 0; t < 4; t++) begin
            weight_ff[t] <= weight_in[t];
         end
      end
      if (ctl.acc_en) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_in[c];
         end
      end
   end

endmodule
